>>> sv/timed_step_sequencer_macros.svh
// Assertion macros for the timed step sequencer.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef TIMED_STEP_SEQUENCER_MACROS_SVH
`define TIMED_STEP_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TSS_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TSS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> sv/tss_pkg.sv
// Shared types and constants for the timed step sequencer.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package tss_pkg;

  localparam int NUM_SEQUENCES_DEFAULT      = 8;
  localparam int STEPS_PER_SEQUENCE_DEFAULT = 16;

  localparam int KIND_W     = 2;
  localparam int MODE_W     = 2;
  localparam int SEQ_IDX_W  = 3;
  localparam int STEP_IDX_W = 4;
  localparam int ACTION_W   = 8;
  localparam int DELAY_W    = 16;
  localparam int TICK_W     = 10;
  localparam int ELAPSED_W  = 32;

  localparam logic [TICK_W-1:0] TICK_PERIOD_RESET = 10'd100;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF    = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_CYCLIC = 2'd2
  } run_mode_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DELAY_W-1:0]  delay;
  } step_entry_t;

endpackage

`default_nettype wire

>>> sv/tss_cmd_if.sv
// Command channel of the timed step sequencer: valid/ready plus one input word.
// Depends on tss_pkg for field widths.
`default_nettype none

interface tss_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [tss_pkg::KIND_W-1:0]       kind;
  logic [tss_pkg::MODE_W-1:0]       run_mode;
  logic [tss_pkg::SEQ_IDX_W-1:0]    sequence_index;
  logic [tss_pkg::STEP_IDX_W-1:0]   step_index;
  logic [tss_pkg::ACTION_W-1:0]     action_code;
  logic [tss_pkg::DELAY_W-1:0]      delay_ms;

  modport source (
    output valid, kind, run_mode, sequence_index, step_index, action_code, delay_ms,
    input  ready
  );

  modport sink (
    input  valid, kind, run_mode, sequence_index, step_index, action_code, delay_ms,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/tss_rsp_if.sv
// Result channel of the timed step sequencer: valid/ready plus one result word.
// Depends on tss_pkg for field widths.
`default_nettype none

interface tss_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             action_fire;
  logic [tss_pkg::ACTION_W-1:0]     fired_action;
  logic [tss_pkg::SEQ_IDX_W-1:0]    fired_sequence;
  logic [tss_pkg::STEP_IDX_W-1:0]   fired_step;
  logic                             active;
  logic [tss_pkg::ELAPSED_W-1:0]    elapsed_time_ms;

  modport source (
    output valid, action_fire, fired_action, fired_sequence, fired_step, active,
           elapsed_time_ms,
    input  ready
  );

  modport sink (
    input  valid, action_fire, fired_action, fired_sequence, fired_step, active,
           elapsed_time_ms,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/tss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read and write of the same address in one cycle return the old data.
`default_nettype none

module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

>>> sv/timed_step_sequencer.sv
// Timed step sequencer: runs timed action sequences from a step table.
// Uses tss_pkg, tss_cmd_if, tss_rsp_if, tss_ram and the assertion macros.
//
// Usage:
//   cmd  - one word per item: a tick, a start (sequence and run mode) or a
//          step table write (sequence, step, action code, delay).
//   rsp  - exactly one result word per command word, in order: whether the
//          tick fired an action, which action and where, whether the
//          sequencer is running, and elapsed milliseconds since the last start.
//   cfg  - cfg_valid/cfg_ready/cfg_data write the tick period in ms; always
//          ready, write only while no command is in flight.
// Path: an accepted command word goes through the second stage, then the
//   output register. Throughput: one word per cycle while the result channel
//   is ready. The step table read is issued in the cycle a word is taken, from
//   the state left by the word ahead, so the read-modify-write loop via the RAM closes.
// Reset: sequencer off, counters zero, tick period 100 ms. The table reads
//   as all zero until written; per-entry valid bits clear at once, so no
//   clearing pass is needed.
// Stall: a held result word keeps its register; one more command word waits
//   in the second stage and the command channel drops ready behind it.
`default_nettype none
`include "timed_step_sequencer_macros.svh"

module timed_step_sequencer #(
  parameter int NUM_SEQUENCES      = tss_pkg::NUM_SEQUENCES_DEFAULT,
  parameter int STEPS_PER_SEQUENCE = tss_pkg::STEPS_PER_SEQUENCE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tss_pkg::TICK_W-1:0]  cfg_data,
  tss_cmd_if.sink                     cmd,
  tss_rsp_if.source                   rsp
);
  import tss_pkg::*;

  localparam int DEPTH  = NUM_SEQUENCES * STEPS_PER_SEQUENCE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SEQ_W  = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int POS_W  = $clog2(STEPS_PER_SEQUENCE + 1);
  localparam int BIT_W  = (STEPS_PER_SEQUENCE > 1) ? $clog2(STEPS_PER_SEQUENCE) : 1;
  localparam int ENTRY_W = $bits(step_entry_t);

  // Configuration
  logic [TICK_W-1:0] tick_period;

  // Second stage: the word waiting for its table data
  logic                  s1_valid;
  logic [KIND_W-1:0]     s1_kind;
  logic [MODE_W-1:0]     s1_mode;
  logic [SEQ_IDX_W-1:0]  s1_seq;
  logic [STEP_IDX_W-1:0] s1_step;
  logic [ACTION_W-1:0]   s1_action;
  logic [DELAY_W-1:0]    s1_delay;
  logic                  s1_go;

  // Sequencer state
  logic [MODE_W-1:0]             run_state, run_state_next;
  logic [SEQ_W-1:0]              cur_seq, cur_seq_next;
  logic [POS_W-1:0]              step_pos, step_pos_next;
  logic [DELAY_W-1:0]            countdown, countdown_next;
  logic [STEPS_PER_SEQUENCE-1:0] started, started_next;
  logic [ELAPSED_W-1:0]          elapsed, elapsed_next;

  // Table access
  logic [DEPTH-1:0]   entry_valid;
  logic               ram_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_in_range_next;
  logic               rd_in_range;
  logic               rd_valid;
  logic               fwd_hit;
  step_entry_t        fwd_entry;
  step_entry_t        wr_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  step_entry_t        entry;
  logic               present;
  logic [BIT_W-1:0]   pos_bit;

  // Result of the word in the second stage
  logic                  fire;
  logic [ACTION_W-1:0]   f_act;
  logic [SEQ_IDX_W-1:0]  f_seq;
  logic [STEP_IDX_W-1:0] f_step;
  logic                  act;
  logic                  seq_in_ok;
  logic                  step_in_ok;

  // Output register
  logic                  out_valid;
  logic                  out_fire;
  logic [ACTION_W-1:0]   out_action;
  logic [SEQ_IDX_W-1:0]  out_seq;
  logic [STEP_IDX_W-1:0] out_step;
  logic                  out_active;
  logic [ELAPSED_W-1:0]  out_elapsed;

  assign cfg_ready = 1'b1;

  // Advance the second stage whenever the output register is free or draining.
  assign s1_go     = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_go;

  assign seq_in_ok  = int'(s1_seq) < NUM_SEQUENCES;
  assign step_in_ok = int'(s1_step) < STEPS_PER_SEQUENCE;

  // Forwarded write data wins; never-written entries read as an empty step.
  always_comb begin
    if (fwd_hit) begin
      entry = fwd_entry;
    end else if (rd_valid) begin
      entry = step_entry_t'(ram_rdata);
    end else begin
      entry = '0;
    end
  end

  assign present  = rd_in_range && (entry.action != '0);
  assign pos_bit  = step_pos[BIT_W-1:0];
  assign wr_addr  = ADDR_W'(int'(s1_seq) * STEPS_PER_SEQUENCE + int'(s1_step));
  assign wr_entry = '{action: s1_action, delay: s1_delay};

  // Next-state logic for the word in the second stage.
  always_comb begin
    run_state_next = run_state;
    cur_seq_next   = cur_seq;
    step_pos_next  = step_pos;
    countdown_next = countdown;
    started_next   = started;
    elapsed_next   = elapsed;
    ram_we         = 1'b0;
    fire           = 1'b0;
    f_act          = '0;
    f_seq          = '0;
    f_step         = '0;
    act            = (run_state != MODE_OFF);

    if (s1_go) begin
      case (s1_kind)
        KIND_TICK: begin
          elapsed_next = elapsed + ELAPSED_W'(tick_period);
          if (run_state != MODE_OFF) begin
            if (present) begin
              if (!started[pos_bit]) begin
                // First tick on this step: fire and load its delay.
                started_next[pos_bit] = 1'b1;
                fire                  = 1'b1;
                f_act                 = entry.action;
                f_seq                 = SEQ_IDX_W'(cur_seq);
                f_step                = STEP_IDX_W'(step_pos);
                countdown_next        = entry.delay;
              end else if (countdown == '0) begin
                step_pos_next = step_pos + POS_W'(1);
              end else if (countdown > DELAY_W'(tick_period)) begin
                countdown_next = countdown - DELAY_W'(tick_period);
              end else begin
                countdown_next = '0;
              end
            end else begin
              // End of sequence: stop, or move on to the next one and re-arm.
              step_pos_next  = '0;
              countdown_next = '0;
              if (run_state == MODE_SINGLE) begin
                run_state_next = MODE_OFF;
              end else begin
                if (cur_seq == SEQ_W'(NUM_SEQUENCES - 1)) begin
                  cur_seq_next = '0;
                end else begin
                  cur_seq_next = cur_seq + SEQ_W'(1);
                end
                started_next = '0;
              end
            end
          end else begin
            cur_seq_next   = '0;
            step_pos_next  = '0;
            countdown_next = '0;
          end
        end
        KIND_START: begin
          if (seq_in_ok) begin
            case (s1_mode)
              MODE_SINGLE: run_state_next = MODE_SINGLE;
              MODE_CYCLIC: run_state_next = MODE_CYCLIC;
              default:     run_state_next = MODE_OFF;
            endcase
            cur_seq_next   = SEQ_W'(s1_seq);
            elapsed_next   = '0;
            step_pos_next  = '0;
            countdown_next = '0;
            started_next   = '0;
          end
          act = (run_state_next != MODE_OFF);
        end
        KIND_WRITE: begin
          ram_we = seq_in_ok && step_in_ok;
        end
        default: begin
          // Unknown kind: drop the word, report no fire.
        end
      endcase
    end
  end

  // Read the entry the next word will need, from the state after this one.
  assign rd_in_range_next = int'(step_pos_next) < STEPS_PER_SEQUENCE;
  assign rd_addr = rd_in_range_next
                   ? ADDR_W'(int'(cur_seq_next) * STEPS_PER_SEQUENCE + int'(step_pos_next))
                   : '0;

  tss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RESET;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      run_state   <= MODE_OFF;
      cur_seq     <= '0;
      step_pos    <= '0;
      countdown   <= '0;
      started     <= '0;
      elapsed     <= '0;
      entry_valid <= '0;
    end else begin
      if (cfg_valid) begin
        tick_period <= cfg_data;
      end
      if (cmd.ready) begin
        s1_valid <= cmd.valid;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      run_state <= run_state_next;
      cur_seq   <= cur_seq_next;
      step_pos  <= step_pos_next;
      countdown <= countdown_next;
      started   <= started_next;
      elapsed   <= elapsed_next;
      if (ram_we) begin
        entry_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload and read-side registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_kind   <= cmd.kind;
      s1_mode   <= cmd.run_mode;
      s1_seq    <= cmd.sequence_index;
      s1_step   <= cmd.step_index;
      s1_action <= cmd.action_code;
      s1_delay  <= cmd.delay_ms;
    end
    rd_in_range <= rd_in_range_next;
    rd_valid    <= entry_valid[rd_addr];
    fwd_hit     <= ram_we && (wr_addr == rd_addr);
    fwd_entry   <= wr_entry;
    if (s1_go) begin
      out_fire    <= fire;
      out_action  <= f_act;
      out_seq     <= f_seq;
      out_step    <= f_step;
      out_active  <= act;
      out_elapsed <= elapsed_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.action_fire     = out_fire;
  assign rsp.fired_action    = out_action;
  assign rsp.fired_sequence  = out_seq;
  assign rsp.fired_step      = out_step;
  assign rsp.active          = out_active;
  assign rsp.elapsed_time_ms = out_elapsed;

  // Checks
  `TSS_ASSERT_IMPL(a_no_write_on_hold, s1_valid && !s1_go, !ram_we,
                   "table written while the second stage is held")
  `TSS_ASSERT_IMPL(a_ready_only_blocked_by_s1, !cmd.ready, s1_valid,
                   "command channel blocked with an empty second stage")
  `TSS_ASSERT_NEXT(a_start_rearms, s1_go && (s1_kind == KIND_START) && seq_in_ok,
                   (step_pos == '0) && (started == '0) && (elapsed == '0),
                   "start did not re-arm the position")
  `TSS_ASSERT_NEXT(a_tick_adds_period, s1_go && (s1_kind == KIND_TICK),
                   elapsed == $past(elapsed + ELAPSED_W'(tick_period)),
                   "tick did not advance elapsed time by the period")
endmodule

`default_nettype wire
